// ===== hw/rtl/mrrb_pkg.sv =====
package mrrb_pkg;

  // buffer geometry, DEPTH must be a power of two so pointers wrap by masking
  localparam int DEPTH        = 1024;
  localparam int SAMPLE_WIDTH = 16;
  localparam int MAX_READERS  = 4;

  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int NREG_W  = $clog2(MAX_READERS + 1);

  // fixed field widths of the stream words
  localparam int CMD_W   = 3;
  localparam int DATA_W  = 16;
  localparam int RD_W    = 2;
  localparam int AMT_W   = 11;
  localparam int STAT_W  = 3;
  localparam int POS_W   = 10;
  localparam int LVL_W   = 11;

  // compare width wide enough for both counts and amounts
  localparam int CMP_W   = (CNT_W > AMT_W) ? CNT_W : AMT_W;

  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [NREG_W-1:0]       nreg_t;
  typedef logic [CMP_W-1:0]        cmp_t;
  typedef logic [SAMPLE_WIDTH-1:0] sample_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE    = 3'd0,
    CMD_CHECK    = 3'd1,
    CMD_FETCH    = 3'd2,
    CMD_ADVANCE  = 3'd3,
    CMD_REGISTER = 3'd4,
    CMD_RESET    = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_NO_SLOT   = 3'd2,
    ST_UNKNOWN   = 3'd3,
    ST_OVERRUN   = 3'd4
  } status_t;

  // one input word
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] data_in;
    logic [RD_W-1:0]   reader;
    logic [AMT_W-1:0]  amount;
  } item_t;

  // result fields known at accept time, data_out comes later for a fetch
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [RD_W-1:0]   reader_id;
    logic [LVL_W-1:0]  level;
  } result_t;

  // sample store access for one word
  typedef struct packed {
    logic    we;
    addr_t   waddr;
    sample_t wdata;
    logic    re;
    addr_t   raddr;
  } ram_req_t;

endpackage

// ===== hw/rtl/multi_reader_ring_buffer_unit.sv =====
// channel   dir  handshake              payload
// s_*       in   s_tvalid / s_tready    command word: cmd, sample, reader, amount
// m_*       out  m_tvalid / m_tready    result word: status, data, position, id, level
//
// every word gives exactly one result word
// a fetch waits for the registered read of the sample RAM, all others do not
// rst clears pointers, counts and registered readers; sample RAM is not cleared
// the output register lets a new word in while the last result is being taken
// a stalled result holds the input off, and so does a fetch in flight
module multi_reader_ring_buffer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // data_in[15:0], reader[17:16], amount[28:18], zero fill
  input  logic [2:0]  s_tuser,   // cmd[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // data_out[15:0], position[25:16], reader_id[27:26],
                                 // level[38:28], zero fill
  output logic [2:0]  m_tuser    // status[2:0]
);

  logic                  accept;
  logic                  pend;
  mrrb_pkg::item_t       item;
  mrrb_pkg::result_t     res;
  mrrb_pkg::result_t     out_res;
  mrrb_pkg::ram_req_t    ram_req;
  mrrb_pkg::sample_t     rdata;
  logic [mrrb_pkg::DATA_W-1:0] out_data;

  // unpack the input word
  assign item.cmd     = s_tuser;
  assign item.data_in = s_tdata[15:0];
  assign item.reader  = s_tdata[17:16];
  assign item.amount  = s_tdata[28:18];

  assign s_tready = !pend && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  mrrb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .item    (item),
    .res     (res),
    .ram_req (ram_req)
  );

  mrrb_ram #(
    .WIDTH (mrrb_pkg::SAMPLE_WIDTH),
    .DEPTH (mrrb_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rdata)
  );

  // output register and fetch wait
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      pend     <= 1'b0;
    end else if (accept) begin
      pend     <= ram_req.re;
      m_tvalid <= !ram_req.re;
    end else if (pend) begin
      pend     <= 1'b0;
      m_tvalid <= 1'b1;
    end else if (m_tvalid && m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_res  <= res;
      out_data <= '0;
    end
    if (pend) begin
      out_data <= mrrb_pkg::DATA_W'(rdata);
    end
  end

  assign m_tdata = {1'b0, out_res.level, out_res.reader_id, out_res.position, out_data};
  assign m_tuser = out_res.status;

  // a fetch in flight always turns into a result next cycle
  a_pend_result: assert property (@(posedge clk) disable iff (rst) pend |=> m_tvalid)
    else $error("fetch result not presented");

  // no word accepted while the sample read is outstanding
  a_pend_block: assert property (@(posedge clk) disable iff (rst) pend |-> !s_tready)
    else $error("input accepted during fetch");

  // a RAM read on accept always leaves a fetch pending
  a_read_pend: assert property (@(posedge clk) disable iff (rst)
    (accept && ram_req.re) |=> (pend && !m_tvalid))
    else $error("fetch read not tracked");

endmodule

// ===== hw/rtl/mrrb_ram.sv =====
module mrrb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/mrrb_ctrl.sv =====
module mrrb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  mrrb_pkg::item_t   item,
  output mrrb_pkg::result_t res,
  output mrrb_pkg::ram_req_t ram_req
);

  // pointer and count registers
  mrrb_pkg::addr_t wp;
  mrrb_pkg::addr_t wp_next;
  mrrb_pkg::addr_t rp [mrrb_pkg::MAX_READERS];
  mrrb_pkg::addr_t rp_next [mrrb_pkg::MAX_READERS];
  mrrb_pkg::cnt_t  cnt [mrrb_pkg::MAX_READERS];
  mrrb_pkg::cnt_t  cnt_next [mrrb_pkg::MAX_READERS];
  mrrb_pkg::nreg_t nreg;
  mrrb_pkg::nreg_t nreg_next;

  logic            known;
  mrrb_pkg::addr_t sel_rp;
  mrrb_pkg::cnt_t  sel_cnt;
  mrrb_pkg::cmp_t  amt_w;
  mrrb_pkg::cmp_t  cnt_w;
  mrrb_pkg::addr_t rp_plus;

  assign known = {{(32 - mrrb_pkg::NREG_W){1'b0}}, nreg} > 32'(item.reader);
  assign amt_w = mrrb_pkg::cmp_t'(item.amount);
  assign cnt_w = mrrb_pkg::cmp_t'(sel_cnt);
  assign rp_plus = mrrb_pkg::addr_t'(mrrb_pkg::cmp_t'(sel_rp) + amt_w);

  // pick the addressed reader
  always_comb begin
    sel_rp  = '0;
    sel_cnt = '0;
    for (int i = 0; i < mrrb_pkg::MAX_READERS; i++) begin
      if (i == int'(item.reader)) begin
        sel_rp  = rp[i];
        sel_cnt = cnt[i];
      end
    end
  end

  // command decode and next state
  always_comb begin
    wp_next   = wp;
    rp_next   = rp;
    cnt_next  = cnt;
    nreg_next = nreg;
    res       = '0;
    ram_req   = '0;
    ram_req.waddr = wp;
    ram_req.wdata = item.data_in[mrrb_pkg::SAMPLE_WIDTH-1:0];
    ram_req.raddr = rp_plus;
    case (item.cmd)
      mrrb_pkg::CMD_WRITE: begin
        ram_req.we = 1'b1;
        wp_next = wp + 1'b1;
        for (int i = 0; i < mrrb_pkg::MAX_READERS; i++) begin
          if (i < int'(nreg)) begin
            if (cnt[i] != mrrb_pkg::cnt_t'(mrrb_pkg::DEPTH)) begin
              cnt_next[i] = cnt[i] + 1'b1;
            end else begin
              res.status = mrrb_pkg::ST_OVERRUN;
            end
          end
        end
      end
      mrrb_pkg::CMD_CHECK: begin
        if (!known) begin
          res.status = mrrb_pkg::ST_UNKNOWN;
        end else if (cnt_w < amt_w) begin
          res.status = mrrb_pkg::ST_SHORT;
        end else begin
          res.position = mrrb_pkg::POS_W'(sel_rp);
        end
      end
      mrrb_pkg::CMD_FETCH: begin
        if (!known) begin
          res.status = mrrb_pkg::ST_UNKNOWN;
        end else begin
          ram_req.re = 1'b1;
        end
      end
      mrrb_pkg::CMD_ADVANCE: begin
        if (!known) begin
          res.status = mrrb_pkg::ST_UNKNOWN;
        end else if (amt_w > cnt_w) begin
          res.status = mrrb_pkg::ST_SHORT;
        end else begin
          for (int i = 0; i < mrrb_pkg::MAX_READERS; i++) begin
            if (i == int'(item.reader)) begin
              cnt_next[i] = mrrb_pkg::cnt_t'(cnt_w - amt_w);
              rp_next[i]  = rp_plus;
            end
          end
        end
      end
      mrrb_pkg::CMD_REGISTER: begin
        if (int'(nreg) >= mrrb_pkg::MAX_READERS) begin
          res.status = mrrb_pkg::ST_NO_SLOT;
        end else begin
          for (int i = 0; i < mrrb_pkg::MAX_READERS; i++) begin
            if (i == int'(nreg)) begin
              rp_next[i]  = wp;
              cnt_next[i] = '0;
            end
          end
          nreg_next     = nreg + 1'b1;
          res.reader_id = mrrb_pkg::RD_W'(nreg);
        end
      end
      mrrb_pkg::CMD_RESET: begin
        wp_next = '0;
        for (int i = 0; i < mrrb_pkg::MAX_READERS; i++) begin
          rp_next[i]  = '0;
          cnt_next[i] = '0;
        end
      end
      default: begin
      end
    endcase
    // level after the step for the addressed reader
    if (item.cmd != mrrb_pkg::CMD_REGISTER && item.cmd != mrrb_pkg::CMD_RESET && known) begin
      for (int i = 0; i < mrrb_pkg::MAX_READERS; i++) begin
        if (i == int'(item.reader)) begin
          res.level = mrrb_pkg::LVL_W'(cnt_next[i]);
        end
      end
    end
    if (!accept) begin
      ram_req.we = 1'b0;
      ram_req.re = 1'b0;
    end
  end

  // state update on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      nreg <= '0;
      for (int i = 0; i < mrrb_pkg::MAX_READERS; i++) begin
        rp[i]  <= '0;
        cnt[i] <= '0;
      end
    end else if (accept) begin
      wp   <= wp_next;
      nreg <= nreg_next;
      rp   <= rp_next;
      cnt  <= cnt_next;
    end
  end

endmodule
